>>> rtl/core/stt_pkg.sv
// Shared types, constants and helper functions of the scene text tokenizer.
// Used by all modules in rtl/core; depends on nothing.
`default_nettype none

package stt_pkg;

  localparam int unsigned InDepth  = 2;
  localparam int unsigned ResDepth = 4;

  localparam logic [1:0] KIND_WORD    = 2'd0;
  localparam logic [1:0] KIND_STRING  = 2'd1;
  localparam logic [1:0] KIND_BRACKET = 2'd2;
  localparam logic [1:0] KIND_COMMENT = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_EOI_STR = 2'd1;
  localparam logic [1:0] ERR_LF_STR  = 2'd2;
  localparam logic [1:0] ERR_ESCAPE  = 2'd3;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_WORD    = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_FAULT   = 3'd5
  } scan_mode_t;

  typedef enum logic [2:0] {
    CL_OTHER   = 3'd0,
    CL_SPACE   = 3'd1,
    CL_CR      = 3'd2,
    CL_LF      = 3'd3,
    CL_QUOTE   = 3'd4,
    CL_BRACKET = 3'd5,
    CL_HASH    = 3'd6,
    CL_BSLASH  = 3'd7
  } char_class_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] token_kind;
    logic       token_first;
    logic       token_last;
    logic [1:0] error_code;
    logic       stream_done;
  } res_item_t;

  typedef struct packed {
    in_item_t    item;
    char_class_t cls;
  } cls_item_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t cl;
    unique case (c) inside
      CH_SPACE, CH_TAB:       cl = CL_SPACE;
      CH_CR:                  cl = CL_CR;
      CH_LF:                  cl = CL_LF;
      CH_QUOTE:               cl = CL_QUOTE;
      CH_LBRACK, CH_RBRACK:   cl = CL_BRACKET;
      CH_HASH:                cl = CL_HASH;
      CH_BSLASH:              cl = CL_BSLASH;
      default:                cl = CL_OTHER;
    endcase
    return cl;
  endfunction

  // {valid, decoded char}
  function automatic logic [8:0] decode_escape(input logic [7:0] c);
    logic [8:0] d;
    unique case (c) inside
      CH_LOW_B:                       d = {1'b1, CH_BS};
      CH_LOW_F:                       d = {1'b1, CH_FF};
      CH_LOW_N:                       d = {1'b1, CH_LF};
      CH_LOW_R:                       d = {1'b1, CH_CR};
      CH_LOW_T:                       d = {1'b1, CH_TAB};
      CH_BSLASH, CH_APOS, CH_QUOTE:   d = {1'b1, c};
      default:                        d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic res_item_t mk_res(input logic [7:0] ch, input logic [1:0] kind,
                                       input logic first, input logic last,
                                       input logic [1:0] err, input logic done);
    res_item_t r;
    r.out_char    = ch;
    r.token_kind  = kind;
    r.token_first = first;
    r.token_last  = last;
    r.error_code  = err;
    r.stream_done = done;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/stt_classifier.sv
// Front part: accepts text items, tags each byte with its character class
// and holds them in a two-entry queue. Depends on stt_pkg.
`default_nettype none

module stt_classifier (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  output logic                 full,
  input  stt_pkg::in_item_t    in_item,
  output logic                 head_valid,
  output stt_pkg::cls_item_t   head,
  input  wire                  take
);

  localparam int unsigned PtrW = $clog2(stt_pkg::InDepth);
  localparam int unsigned CntW = $clog2(stt_pkg::InDepth + 1);

  stt_pkg::cls_item_t mem_r [stt_pkg::InDepth];
  logic [PtrW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic do_push, do_take;

  assign full       = (count_r == CntW'(stt_pkg::InDepth));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rptr_r];
  assign do_push    = push && !full;
  assign do_take    = take && head_valid;

  always_comb begin
    wptr_nxt  = do_push ? PtrW'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt  = do_take ? PtrW'(rptr_r + 1'b1) : rptr_r;
    count_nxt = count_r + CntW'(do_push) - CntW'(do_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r].item <= in_item;
      mem_r[wptr_r].cls  <= stt_pkg::classify(in_item.text_byte);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/stt_result_queue.sv
// Result queue: takes up to two result words per cycle, hands out one.
// Depends on stt_pkg.
`default_nettype none

module stt_result_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  wr0_valid,
  input  stt_pkg::res_item_t   wr0,
  input  wire                  wr1_valid,
  input  stt_pkg::res_item_t   wr1,
  output logic [$clog2(stt_pkg::ResDepth+1)-1:0] count,
  output logic                 empty,
  output stt_pkg::res_item_t   out_item,
  input  wire                  pop
);

  localparam int unsigned PtrW = $clog2(stt_pkg::ResDepth);
  localparam int unsigned CntW = $clog2(stt_pkg::ResDepth + 1);

  stt_pkg::res_item_t mem_r [stt_pkg::ResDepth];
  logic [PtrW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt, wptr1;
  logic [CntW-1:0] count_r, count_nxt;
  logic do_pop;

  assign count    = count_r;
  assign empty    = (count_r == '0);
  assign out_item = mem_r[rptr_r];
  assign do_pop   = pop && !empty;
  assign wptr1    = PtrW'(wptr_r + 1'b1);

  always_comb begin
    wptr_nxt  = PtrW'(wptr_r + PtrW'(wr0_valid) + PtrW'(wr1_valid));
    rptr_nxt  = do_pop ? PtrW'(rptr_r + 1'b1) : rptr_r;
    count_nxt = count_r + CntW'(wr0_valid) + CntW'(wr1_valid) - CntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr0_valid) begin
      mem_r[wptr_r] <= wr0;
    end
    if (wr1_valid) begin
      mem_r[wptr1] <= wr1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/stt_scanner.sv
// Back part: scan mode machine and held character; turns each classified
// item into zero to two result words. Depends on stt_pkg.
`default_nettype none

module stt_scanner (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  emit_comments,
  input  wire                  head_valid,
  input  stt_pkg::cls_item_t   head,
  input  wire                  room,
  output logic                 take,
  output logic                 wr0_valid,
  output stt_pkg::res_item_t   wr0,
  output logic                 wr1_valid,
  output stt_pkg::res_item_t   wr1
);

  stt_pkg::scan_mode_t mode_r, mode_nxt;
  logic [7:0] held_char_r, held_char_nxt;
  logic       held_first_r, held_first_nxt;
  logic       held_valid_r, held_valid_nxt;

  logic [7:0] c;
  stt_pkg::char_class_t cls;
  logic [8:0] esc;
  logic       eoi, term, line_end;
  logic       flush_ok;
  logic [1:0] flush_kind;
  stt_pkg::res_item_t st_res, ra, rb, done_res, err_res;
  logic       st_valid, st_hold, rav, rbv;
  stt_pkg::scan_mode_t st_mode;

  assign take       = head_valid && room;
  assign c          = head.item.text_byte;
  assign cls        = head.cls;
  assign eoi        = head.item.end_of_input;
  assign esc        = stt_pkg::decode_escape(c);
  assign term       = cls inside {stt_pkg::CL_SPACE, stt_pkg::CL_CR, stt_pkg::CL_LF,
                                  stt_pkg::CL_QUOTE, stt_pkg::CL_BRACKET};
  assign line_end   = (cls == stt_pkg::CL_CR) || (cls == stt_pkg::CL_LF);
  assign flush_ok   = held_valid_r &&
                      ((mode_r != stt_pkg::MODE_COMMENT) || emit_comments);
  assign flush_kind = (mode_r == stt_pkg::MODE_COMMENT) ? stt_pkg::KIND_COMMENT
                                                        : stt_pkg::KIND_WORD;
  assign done_res   = stt_pkg::mk_res(8'd0, stt_pkg::KIND_WORD, 1'b0, 1'b0,
                                      stt_pkg::ERR_NONE, 1'b1);

  // start of a new token from idle or after a word terminator
  always_comb begin
    st_res   = stt_pkg::mk_res(c, stt_pkg::KIND_WORD, 1'b1, 1'b0, stt_pkg::ERR_NONE, 1'b0);
    st_valid = 1'b0;
    st_hold  = 1'b0;
    case (cls) inside
      stt_pkg::CL_SPACE, stt_pkg::CL_CR, stt_pkg::CL_LF: begin
        st_mode = stt_pkg::MODE_IDLE;
      end
      stt_pkg::CL_QUOTE: begin
        st_mode  = stt_pkg::MODE_STRING;
        st_valid = 1'b1;
        st_res   = stt_pkg::mk_res(c, stt_pkg::KIND_STRING, 1'b1, 1'b0,
                                   stt_pkg::ERR_NONE, 1'b0);
      end
      stt_pkg::CL_BRACKET: begin
        st_mode  = stt_pkg::MODE_IDLE;
        st_valid = 1'b1;
        st_res   = stt_pkg::mk_res(c, stt_pkg::KIND_BRACKET, 1'b1, 1'b1,
                                   stt_pkg::ERR_NONE, 1'b0);
      end
      stt_pkg::CL_HASH: begin
        st_mode = stt_pkg::MODE_COMMENT;
        st_hold = 1'b1;
      end
      default: begin
        st_mode = stt_pkg::MODE_WORD;
        st_hold = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    if (take) begin
      if (eoi) begin
        mode_nxt = stt_pkg::MODE_IDLE;
      end else begin
        unique case (mode_r)
          stt_pkg::MODE_WORD: begin
            mode_nxt = term ? st_mode : stt_pkg::MODE_WORD;
          end
          stt_pkg::MODE_COMMENT: begin
            mode_nxt = line_end ? stt_pkg::MODE_IDLE : stt_pkg::MODE_COMMENT;
          end
          stt_pkg::MODE_STRING: begin
            case (cls)
              stt_pkg::CL_QUOTE:  mode_nxt = stt_pkg::MODE_IDLE;
              stt_pkg::CL_LF:     mode_nxt = stt_pkg::MODE_FAULT;
              stt_pkg::CL_BSLASH: mode_nxt = stt_pkg::MODE_ESCAPE;
              default:            mode_nxt = stt_pkg::MODE_STRING;
            endcase
          end
          stt_pkg::MODE_ESCAPE: begin
            mode_nxt = esc[8] ? stt_pkg::MODE_STRING : stt_pkg::MODE_FAULT;
          end
          stt_pkg::MODE_FAULT: begin
            mode_nxt = stt_pkg::MODE_FAULT;
          end
          default: begin
            mode_nxt = st_mode;
          end
        endcase
      end
    end
  end

  // results and held character
  always_comb begin
    held_char_nxt  = held_char_r;
    held_first_nxt = held_first_r;
    held_valid_nxt = held_valid_r;
    ra  = done_res;
    rb  = done_res;
    rav = 1'b0;
    rbv = 1'b0;
    err_res = stt_pkg::mk_res(8'd0, stt_pkg::KIND_WORD, 1'b0, 1'b0,
                              stt_pkg::ERR_NONE, 1'b0);
    if (take) begin
      if (eoi) begin
        held_valid_nxt = 1'b0;
        held_first_nxt = 1'b0;
        held_char_nxt  = 8'd0;
        rbv = 1'b1;
        unique case (mode_r) inside
          stt_pkg::MODE_WORD, stt_pkg::MODE_COMMENT: begin
            rav = flush_ok;
            ra  = stt_pkg::mk_res(held_char_r, flush_kind, held_first_r, 1'b1,
                                  stt_pkg::ERR_NONE, 1'b0);
          end
          stt_pkg::MODE_STRING, stt_pkg::MODE_ESCAPE: begin
            rav = 1'b1;
            err_res.error_code = stt_pkg::ERR_EOI_STR;
            ra  = err_res;
          end
          default: begin
            rav = 1'b0;
          end
        endcase
      end else begin
        unique case (mode_r) inside
          stt_pkg::MODE_WORD, stt_pkg::MODE_COMMENT: begin
            rav = flush_ok;
            if ((mode_r == stt_pkg::MODE_WORD) ? term : line_end) begin
              ra = stt_pkg::mk_res(held_char_r, flush_kind, held_first_r, 1'b1,
                                   stt_pkg::ERR_NONE, 1'b0);
              held_valid_nxt = 1'b0;
              held_first_nxt = 1'b0;
              held_char_nxt  = 8'd0;
              if (mode_r == stt_pkg::MODE_WORD) begin
                rbv = st_valid;
                rb  = st_res;
                if (st_hold) begin
                  held_char_nxt  = c;
                  held_first_nxt = 1'b1;
                  held_valid_nxt = 1'b1;
                end
              end
            end else begin
              ra = stt_pkg::mk_res(held_char_r, flush_kind, held_first_r, 1'b0,
                                   stt_pkg::ERR_NONE, 1'b0);
              held_char_nxt  = c;
              held_first_nxt = 1'b0;
              held_valid_nxt = 1'b1;
            end
          end
          stt_pkg::MODE_STRING: begin
            case (cls)
              stt_pkg::CL_QUOTE: begin
                rav = 1'b1;
                ra  = stt_pkg::mk_res(c, stt_pkg::KIND_STRING, 1'b0, 1'b1,
                                      stt_pkg::ERR_NONE, 1'b0);
              end
              stt_pkg::CL_LF: begin
                rav = 1'b1;
                err_res.error_code = stt_pkg::ERR_LF_STR;
                ra  = err_res;
              end
              stt_pkg::CL_BSLASH: begin
                rav = 1'b0;
              end
              default: begin
                rav = 1'b1;
                ra  = stt_pkg::mk_res(c, stt_pkg::KIND_STRING, 1'b0, 1'b0,
                                      stt_pkg::ERR_NONE, 1'b0);
              end
            endcase
          end
          stt_pkg::MODE_ESCAPE: begin
            rav = 1'b1;
            if (esc[8]) begin
              ra = stt_pkg::mk_res(esc[7:0], stt_pkg::KIND_STRING, 1'b0, 1'b0,
                                   stt_pkg::ERR_NONE, 1'b0);
            end else begin
              err_res.error_code = stt_pkg::ERR_ESCAPE;
              ra = err_res;
            end
          end
          stt_pkg::MODE_FAULT: begin
            rav = 1'b0;
          end
          default: begin
            rav = st_valid;
            ra  = st_res;
            if (st_hold) begin
              held_char_nxt  = c;
              held_first_nxt = 1'b1;
              held_valid_nxt = 1'b1;
            end
          end
        endcase
      end
    end
    // pack results toward the first write slot
    wr0_valid = rav || rbv;
    wr0       = rav ? ra : rb;
    wr1_valid = rav && rbv;
    wr1       = rb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= stt_pkg::MODE_IDLE;
      held_char_r  <= 8'd0;
      held_first_r <= 1'b0;
      held_valid_r <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      held_char_r  <= held_char_nxt;
      held_first_r <= held_first_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/scene_text_tokenizer.sv
// Top level of the scene text tokenizer: classifier front, scanner back and
// result queue. Depends on stt_pkg, stt_classifier, stt_scanner, stt_result_queue.
//
// Push one text byte (or an end-of-input mark) per cycle; each item gives
// zero, one or two result words (token characters with kind and first/last
// flags, error words, and a closing done word after end of input). The
// block sustains one item per cycle as long as the result side pops at least
// as many words as are produced; the result queue hands out one word per
// cycle, so an item that yields two words needs two pops. A result word
// shows on the result ports once the scanner, at the edge that takes its
// item from the two-entry input queue, has written its words into the
// four-entry result queue; it takes an item only when that queue has room
// for two words. The last character of a word or comment comes out only
// once the byte ending it arrives. The user must write emit_comments through
// the cfg port only while no text is in flight; the block does not enforce it.
`default_nettype none

module scene_text_tokenizer (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  output logic                 full,
  input  stt_pkg::in_item_t    in_item,
  output logic                 empty,
  output stt_pkg::res_item_t   out_item,
  input  wire                  pop,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire                  cfg_data
);

  localparam int unsigned CntW = $clog2(stt_pkg::ResDepth + 1);

  logic emit_r, emit_nxt;
  logic head_valid, take, room;
  stt_pkg::cls_item_t head;
  logic wr0_valid, wr1_valid;
  stt_pkg::res_item_t wr0, wr1;
  logic [CntW-1:0] resq_count;

  assign cfg_ready = 1'b1;
  assign emit_nxt  = (cfg_valid && cfg_ready) ? cfg_data : emit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
    end else begin
      emit_r <= emit_nxt;
    end
  end

  stt_classifier u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head       (head),
    .take       (take)
  );

  assign room = (resq_count <= CntW'(stt_pkg::ResDepth - 2));

  stt_scanner u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .emit_comments (emit_r),
    .head_valid    (head_valid),
    .head          (head),
    .room          (room),
    .take          (take),
    .wr0_valid     (wr0_valid),
    .wr0           (wr0),
    .wr1_valid     (wr1_valid),
    .wr1           (wr1)
  );

  stt_result_queue u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr0_valid (wr0_valid),
    .wr0       (wr0),
    .wr1_valid (wr1_valid),
    .wr1       (wr1),
    .count     (resq_count),
    .empty     (empty),
    .out_item  (out_item),
    .pop       (pop)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    resq_count <= CntW'(stt_pkg::ResDepth))
    else $error("result queue overflow");

  a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> resq_count <= CntW'(stt_pkg::ResDepth - 2))
    else $error("scanner fired without room for two words");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    wr1_valid |-> wr0_valid)
    else $error("second result word written without the first");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.stream_done) |->
      (out_item.error_code == stt_pkg::ERR_NONE && out_item.out_char == 8'd0))
    else $error("done word carries data");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

endmodule

`default_nettype wire

>>> verif/scene_text_tokenizer_chk.sv
// Checker for the scene text tokenizer: watches the input, result and cfg channels,
// predicts the token words of every accepted byte and compares them in order.
// Depends on stt_pkg for the channel types and character codes.
module scene_text_tokenizer_chk
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  logic      full,
  input  in_item_t  in_item,
  input  logic      empty,
  input  logic      pop,
  input  res_item_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_data,
  output int        fail_count,
  output int        pending,
  output int        words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  scan_mode_t mode;
  logic [7:0] held_char;
  logic       held_first;
  logic       held_valid;
  logic       emit_on;
  res_item_t  token_words_q[$];

  function automatic bit is_gap(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  task automatic expect_word(logic [7:0] ch, logic [1:0] kind, logic first, logic last,
                             logic [1:0] err, logic done);
    token_words_q.insert(token_words_q.size(),
                         res_item_t'({ch, kind, first, last, err, done}));
  endtask

  task automatic keep_char(logic [7:0] c, logic first);
    held_char  = c;
    held_first = first;
    held_valid = 1'b1;
  endtask

  task automatic release_held(logic last);
    if (held_valid && (mode != MODE_COMMENT || emit_on)) begin
      expect_word(held_char, (mode == MODE_COMMENT) ? KIND_COMMENT : KIND_WORD,
                  held_first, last, ERR_NONE, 1'b0);
    end
    held_valid = 1'b0;
    held_first = 1'b0;
    held_char  = 8'h00;
  endtask

  task automatic open_token(logic [7:0] c);
    if (is_gap(c)) begin
      mode = MODE_IDLE;
    end else if (c == CH_QUOTE) begin
      expect_word(c, KIND_STRING, 1'b1, 1'b0, ERR_NONE, 1'b0);
      mode = MODE_STRING;
    end else if (c == CH_LBRACK || c == CH_RBRACK) begin
      expect_word(c, KIND_BRACKET, 1'b1, 1'b1, ERR_NONE, 1'b0);
      mode = MODE_IDLE;
    end else if (c == CH_HASH) begin
      mode = MODE_COMMENT;
      keep_char(c, 1'b1);
    end else begin
      mode = MODE_WORD;
      keep_char(c, 1'b1);
    end
  endtask

  task automatic tokenize_byte(in_item_t it);
    logic [7:0] c;
    logic [7:0] esc_char;
    logic       esc_ok;
    c = it.text_byte;
    if (it.end_of_input) begin
      if (mode == MODE_WORD || mode == MODE_COMMENT) begin
        release_held(1'b1);
      end else if (mode == MODE_STRING || mode == MODE_ESCAPE) begin
        expect_word(8'h00, KIND_WORD, 1'b0, 1'b0, ERR_EOI_STR, 1'b0);
      end
      held_valid = 1'b0;
      held_first = 1'b0;
      held_char  = 8'h00;
      mode       = MODE_IDLE;
      expect_word(8'h00, KIND_WORD, 1'b0, 1'b0, ERR_NONE, 1'b1);
    end else begin
      case (mode)
        MODE_WORD: begin
          if (is_gap(c) || c == CH_QUOTE || c == CH_LBRACK || c == CH_RBRACK) begin
            release_held(1'b1);
            open_token(c);
          end else begin
            release_held(1'b0);
            keep_char(c, 1'b0);
          end
        end
        MODE_COMMENT: begin
          if (c == CH_LF || c == CH_CR) begin
            release_held(1'b1);
            mode = MODE_IDLE;
          end else begin
            release_held(1'b0);
            keep_char(c, 1'b0);
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            expect_word(c, KIND_STRING, 1'b0, 1'b1, ERR_NONE, 1'b0);
            mode = MODE_IDLE;
          end else if (c == CH_LF) begin
            expect_word(8'h00, KIND_WORD, 1'b0, 1'b0, ERR_LF_STR, 1'b0);
            mode = MODE_FAULT;
          end else if (c == CH_BSLASH) begin
            mode = MODE_ESCAPE;
          end else begin
            expect_word(c, KIND_STRING, 1'b0, 1'b0, ERR_NONE, 1'b0);
          end
        end
        MODE_ESCAPE: begin
          esc_ok = 1'b1;
          case (c) inside
            CH_LOW_B: esc_char = CH_BS;
            CH_LOW_F: esc_char = CH_FF;
            CH_LOW_N: esc_char = CH_LF;
            CH_LOW_R: esc_char = CH_CR;
            CH_LOW_T: esc_char = CH_TAB;
            CH_BSLASH, CH_APOS, CH_QUOTE: esc_char = c;
            default: begin
              esc_char = 8'h00;
              esc_ok   = 1'b0;
            end
          endcase
          if (esc_ok) begin
            expect_word(esc_char, KIND_STRING, 1'b0, 1'b0, ERR_NONE, 1'b0);
            mode = MODE_STRING;
          end else begin
            expect_word(8'h00, KIND_WORD, 1'b0, 1'b0, ERR_ESCAPE, 1'b0);
            mode = MODE_FAULT;
          end
        end
        MODE_FAULT: begin
        end
        default: open_token(c);
      endcase
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_item_t want;
    if (!rst_n) begin
      mode       = MODE_IDLE;
      held_char  = 8'h00;
      held_first = 1'b0;
      held_valid = 1'b0;
      emit_on    = 1'b0;
      token_words_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        emit_on = cfg_data;
      end
      if (push && !full) begin
        tokenize_byte(in_item);
      end
      if (pop && !empty) begin
        if (token_words_q.size() == 0) begin
          $error("result word %h with nothing expected", out_item);
          fail_count++;
        end else begin
          want = token_words_q.pop_front();
          check_field("out_char", want.out_char, out_item.out_char);
          check_field("token_kind", 8'(want.token_kind), 8'(out_item.token_kind));
          check_field("token_first", 8'(want.token_first), 8'(out_item.token_first));
          check_field("token_last", 8'(want.token_last), 8'(out_item.token_last));
          check_field("error_code", 8'(want.error_code), 8'(out_item.error_code));
          check_field("stream_done", 8'(want.stream_done), 8'(out_item.stream_done));
        end
        words_checked++;
      end
    end
    pending = token_words_q.size();
  end

endmodule

>>> verif/scene_text_tokenizer_tb.sv
// Testbench top for the scene text tokenizer: clock, reset, text stimulus,
// output pacing and verdict. Depends on stt_pkg, the block and scene_text_tokenizer_chk.
module scene_text_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stt_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int HoldOffCycles = 300;
  localparam int PhaseItems = 170;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  res_item_t out_item;
  logic      pop;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  int chk_fails;
  int chk_pending;
  int chk_words;

  int send_idle_pct;
  int rcv_stall_pct;
  int hold_requests;
  int hold_served;
  int hold_left;
  int items_sent;
  int live_items;
  int phase_count;
  int cycle_count;
  bit in_fault;

  logic [7:0] esc_codes [8] = '{CH_LOW_B, CH_LOW_F, CH_LOW_N, CH_LOW_R,
                                CH_LOW_T, CH_BSLASH, CH_APOS, CH_QUOTE};
  logic [7:0] gap_chars [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

  scene_text_tokenizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .out_item  (out_item),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  scene_text_tokenizer_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_item       (in_item),
    .empty         (empty),
    .pop           (pop),
    .out_item      (out_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (chk_fails),
    .pending       (chk_pending),
    .words_checked (chk_words)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = HoldOffCycles;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  function automatic bit ends_word(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
           c == CH_QUOTE || c == CH_LBRACK || c == CH_RBRACK;
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    case ($urandom_range(3))
      0: c = 8'($urandom_range(8'h7a, 8'h61));
      1: c = 8'($urandom_range(8'h39, 8'h30));
      default: begin
        do c = 8'($urandom_range(255)); while (ends_word(c));
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] string_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_LF || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] comment_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_LF || c == CH_CR);
    return c;
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    if (!in_fault) live_items++;
    @(negedge clk);
  endtask

  task automatic send_char(logic [7:0] c);
    send_item(in_item_t'({c, 1'b0}));
  endtask

  task automatic send_end();
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    send_item(in_item_t'({junk, 1'b1}));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_comments(logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_token();
    int n;
    case ($urandom_range(9)) inside
      [0:3]: begin
        n = $urandom_range(6, 1);
        repeat (n) send_char(word_char());
      end
      [4:5]: begin
        send_char(CH_QUOTE);
        n = $urandom_range(6);
        repeat (n) begin
          if ($urandom_range(9) < 3) begin
            send_char(CH_BSLASH);
            send_char(esc_codes[3'($urandom_range(7))]);
          end else begin
            send_char(string_char());
          end
        end
        send_char(CH_QUOTE);
      end
      6: send_char($urandom_range(1) ? CH_LBRACK : CH_RBRACK);
      7: begin
        send_char(CH_HASH);
        n = $urandom_range(6);
        repeat (n) send_char(comment_char());
        send_char($urandom_range(1) ? CH_LF : CH_CR);
      end
      default: begin
        n = $urandom_range(3, 1);
        repeat (n) send_char(gap_chars[2'($urandom_range(3))]);
      end
    endcase
  endtask

  task automatic broken_sequence();
    logic [7:0] c;
    int n;
    send_char(CH_QUOTE);
    n = $urandom_range(3);
    repeat (n) send_char(string_char());
    case ($urandom_range(3))
      0: send_char(CH_LF);
      1: begin
        send_char(CH_BSLASH);
        if ($urandom_range(3) == 0) begin
          c = CH_LF;
        end else begin
          do c = 8'($urandom_range(255));
          while (c == CH_LOW_B || c == CH_LOW_F || c == CH_LOW_N || c == CH_LOW_R ||
                 c == CH_LOW_T || c == CH_BSLASH || c == CH_APOS || c == CH_QUOTE);
        end
        send_char(c);
      end
      2: begin
        send_end();
        return;
      end
      default: begin
        send_char(CH_BSLASH);
        send_end();
        return;
      end
    endcase
    in_fault = 1'b1;
    n = $urandom_range(3);
    repeat (n) send_char(8'($urandom_range(255)));
    send_end();
    in_fault = 1'b0;
  endtask

  task automatic random_step();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 85) begin
      random_token();
      if ($urandom_range(2) == 0) send_char(gap_chars[2'($urandom_range(3))]);
    end else if (r < 93) begin
      n = $urandom_range(6, 1);
      repeat (n) send_char(8'($urandom_range(255)));
      if ($urandom_range(1)) send_end();
    end else if (r < 98) begin
      broken_sequence();
    end else begin
      send_end();
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, logic emit, int count);
    int start;
    send_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
    write_comments(emit);
    start = live_items;
    while (live_items - start < count) random_step();
    send_end();
    wait_drained();
    phase_count++;
  endtask

  initial begin
    rst_n     = 1'b0;
    push      = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // comments dropped: brackets, word ended by bracket, escaped string, held word at end
    write_comments(1'b0);
    send_char(CH_LBRACK);
    send_char(CH_RBRACK);
    send_char("a");
    send_char(CH_LBRACK);
    send_char(CH_QUOTE);
    send_char(CH_BSLASH);
    send_char(CH_LOW_N);
    send_char(CH_CR);
    send_char(8'hff);
    send_char(CH_QUOTE);
    send_char(CH_HASH);
    send_char("c");
    send_char(CH_LF);
    send_char("q");
    send_char(CH_TAB);
    send_char(8'h00);
    send_end();
    wait_drained();

    // comments passed: comment ended by CR, then each string fault
    write_comments(1'b1);
    send_char(CH_HASH);
    send_char("x");
    send_char(CH_CR);
    send_char(CH_QUOTE);
    send_char("a");
    send_end();
    send_char(CH_QUOTE);
    send_char(CH_LF);
    send_char(8'h00);
    send_end();
    send_char(CH_QUOTE);
    send_char(CH_BSLASH);
    send_char(CH_LF);
    send_end();
    wait_drained();
    phase_count++;

    run_phase(0, 0, 1'b0, PhaseItems);
    run_phase(82, 0, 1'b1, PhaseItems);
    run_phase(0, 82, 1'b0, PhaseItems);
    run_phase(20, 20, 1'b1, PhaseItems);
    run_phase(0, 0, 1'b1, PhaseItems);
    run_phase(82, 0, 1'b0, PhaseItems);
    run_phase(0, 82, 1'b1, PhaseItems);
    run_phase(20, 20, 1'b0, PhaseItems);

    // hold the output side off while text keeps coming, then pause until drained
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_requests++;
    repeat (40) random_token();
    wait_drained();
    repeat (40) random_token();
    send_end();
    wait_drained();
    phase_count++;

    $display("summary: %0d input words accepted, %0d result words checked in %0d phases",
             items_sent, chk_words, phase_count);
    $display("summary: comment output on and off, mixed idle and stall, one long hold-off");
    if (chk_fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
